// ----- hw/rtl/source_map_vlq_mapping_decoder_core_macros.svh -----
// Assertion macros shared by the VLQ mappings decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SOURCE_MAP_VLQ_MAPPING_DECODER_CORE_MACROS_SVH
`define SOURCE_MAP_VLQ_MAPPING_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define SMVLQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smvlq assertion failed");

// Next-cycle implication.
`define SMVLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smvlq assertion failed");

`endif

// ----- hw/rtl/smvlq_pkg.sv -----
// Package for the VLQ mappings decoder: sizes, codes, beat structs and
// the base64 digit lookup. No dependencies.
package smvlq_pkg;

   localparam int MAX_VLQ_DIGITS = 7;
   localparam int ACC_WIDTH      = 32;
   localparam int PV_WIDTH       = 32;
   localparam int DIGIT_BITS     = 5;
   localparam int DC_WIDTH       = $clog2(MAX_VLQ_DIGITS + 1);
   localparam int FIELD_WIDTH    = 3;
   localparam int SHAMT_WIDTH    = $clog2(DIGIT_BITS * MAX_VLQ_DIGITS + 1);

   localparam logic [FIELD_WIDTH-1:0] FIELD_GEN_COLUMN = 3'd0;
   localparam logic [FIELD_WIDTH-1:0] FIELD_SRC_INDEX  = 3'd1;
   localparam logic [FIELD_WIDTH-1:0] FIELD_SRC_LINE   = 3'd2;
   localparam logic [FIELD_WIDTH-1:0] FIELD_SRC_COLUMN = 3'd3;
   localparam logic [FIELD_WIDTH-1:0] FIELD_LIMIT      = 3'd5;

   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;

   localparam logic STATUS_RECORD = 1'b0;
   localparam logic STATUS_ERROR  = 1'b1;

   typedef struct packed {
      logic       valid;
      logic [7:0] map_char;
      logic       end_of_map;
   } smvlq_item_type;

   typedef struct packed {
      logic        status;
      logic [31:0] out_gen_line;
      logic [31:0] out_gen_column;
      logic [15:0] out_source_index;
      logic [31:0] out_source_line;
      logic [31:0] out_source_column;
   } smvlq_result_type;

   typedef struct packed {
      logic             has_result;
      smvlq_result_type result;
   } smvlq_eng_out_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } smvlq_digit_type;

   function automatic smvlq_digit_type b64_decode(input logic [7:0] c);
      smvlq_digit_type d;
      d.ok    = 1'b1;
      d.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         d.value = 6'd62;
      end else if (c == 8'h2F) begin
         d.value = 6'd63;
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

// ----- hw/rtl/smvlq_channels.sv -----
// Valid/ready channel interfaces for the character input and result output.
// Depends on nothing.
interface smvlq_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] map_char;
   logic       end_of_map;
   modport source (output valid, map_char, end_of_map, input ready);
   modport sink   (input valid, map_char, end_of_map, output ready);
endinterface

interface smvlq_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] out_gen_line;
   logic [31:0] out_gen_column;
   logic [15:0] out_source_index;
   logic [31:0] out_source_line;
   logic [31:0] out_source_column;
   modport source (output valid, status, out_gen_line, out_gen_column, out_source_index,
                   out_source_line, out_source_column, input ready);
   modport sink   (input valid, status, out_gen_line, out_gen_column, out_source_index,
                   out_source_line, out_source_column, output ready);
endinterface

// ----- hw/rtl/smvlq_input_stage.sv -----
// Input register for character beats.
// Depends on smvlq_pkg and smvlq_req_if.
module smvlq_input_stage (
   input  logic                    clock,
   input  logic                    reset,
   smvlq_req_if.sink               req_ch,
   input  logic                    take,
   output smvlq_pkg::smvlq_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;

   // Free when empty or when the held beat is consumed this cycle.
   assign req_ch.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ch.ready) valid_in = req_ch.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         char_ff <= req_ch.map_char;
         last_ff <= req_ch.end_of_map;
      end
   end

   assign item.valid      = valid_ff;
   assign item.map_char   = char_ff;
   assign item.end_of_map = last_ff;

endmodule

// ----- hw/rtl/smvlq_decode_engine.sv -----
// VLQ digit decode, field accumulators and record/error formation.
// Depends on smvlq_pkg and the macros header.
`include "source_map_vlq_mapping_decoder_core_macros.svh"

module smvlq_decode_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data,
   input  smvlq_pkg::smvlq_item_type   item,
   input  logic                        fire,
   output smvlq_pkg::smvlq_eng_out_type eng
);

   logic [15:0]                             source_count_ff;
   logic [smvlq_pkg::ACC_WIDTH-1:0]         gen_line_ff, gen_line_in;
   logic [smvlq_pkg::ACC_WIDTH-1:0]         gen_col_ff, gen_col_in;
   logic [smvlq_pkg::ACC_WIDTH-1:0]         src_idx_ff, src_idx_in;
   logic [smvlq_pkg::ACC_WIDTH-1:0]         src_line_ff, src_line_in;
   logic [smvlq_pkg::ACC_WIDTH-1:0]         src_col_ff, src_col_in;
   logic [smvlq_pkg::PV_WIDTH-1:0]          partial_ff, partial_in;
   logic [smvlq_pkg::DC_WIDTH-1:0]          dcount_ff, dcount_in;
   logic [smvlq_pkg::FIELD_WIDTH-1:0]       field_ff, field_in;
   logic                                    skip_ff, skip_in;

   smvlq_pkg::smvlq_digit_type              dig;
   logic                                    is_sep;
   logic [smvlq_pkg::SHAMT_WIDTH-1:0]       shamt;

   assign dig    = smvlq_pkg::b64_decode(item.map_char);
   assign is_sep = (item.map_char == smvlq_pkg::CHAR_SEMICOLON) ||
                   (item.map_char == smvlq_pkg::CHAR_COMMA);
   assign shamt  = smvlq_pkg::SHAMT_WIDTH'(dcount_ff) *
                   smvlq_pkg::SHAMT_WIDTH'(smvlq_pkg::DIGIT_BITS);

   always_comb begin
      logic                            err_early;
      logic                            err;
      logic                            rec;
      logic [smvlq_pkg::PV_WIDTH-1:0]  shifted;
      logic [smvlq_pkg::PV_WIDTH-1:0]  mag;
      logic [smvlq_pkg::ACC_WIDTH-1:0] delta;
      logic [smvlq_pkg::DC_WIDTH-1:0]  dcount_inc;

      gen_line_in = gen_line_ff;
      gen_col_in  = gen_col_ff;
      src_idx_in  = src_idx_ff;
      src_line_in = src_line_ff;
      src_col_in  = src_col_ff;
      partial_in  = partial_ff;
      dcount_in   = dcount_ff;
      field_in    = field_ff;
      skip_in     = skip_ff;
      err_early   = 1'b0;
      err         = 1'b0;
      rec         = 1'b0;
      shifted     = '0;
      mag         = '0;
      delta       = '0;
      dcount_inc  = '0;
      eng         = '0;

      if (fire) begin
         if (is_sep) begin
            // separator inside an unfinished run reports against the old position
            err_early  = (dcount_ff != '0);
            partial_in = '0;
            dcount_in  = '0;
            if (item.map_char == smvlq_pkg::CHAR_SEMICOLON) begin
               gen_line_in = gen_line_ff + 1'b1;
               gen_col_in  = '0;
            end
            field_in = '0;
            skip_in  = 1'b0;
         end else if (!dig.ok) begin
            partial_in = '0;
            dcount_in  = '0;
            skip_in    = 1'b1;
            err        = 1'b1;
         end else if (!skip_ff) begin
            shifted    = partial_ff |
                         (smvlq_pkg::PV_WIDTH'(dig.value[smvlq_pkg::DIGIT_BITS-1:0]) << shamt);
            dcount_inc = dcount_ff + 1'b1;
            if (!dig.value[smvlq_pkg::DIGIT_BITS]) begin
               mag        = shifted >> 1;
               delta      = shifted[0] ? smvlq_pkg::ACC_WIDTH'('0 - mag)
                                       : smvlq_pkg::ACC_WIDTH'(mag);
               partial_in = '0;
               dcount_in  = '0;
               case (field_ff)
                  smvlq_pkg::FIELD_GEN_COLUMN: gen_col_in  = gen_col_ff + delta;
                  smvlq_pkg::FIELD_SRC_INDEX:  src_idx_in  = src_idx_ff + delta;
                  smvlq_pkg::FIELD_SRC_LINE:   src_line_in = src_line_ff + delta;
                  smvlq_pkg::FIELD_SRC_COLUMN: begin
                     src_col_in = src_col_ff + delta;
                     rec = !src_idx_ff[smvlq_pkg::ACC_WIDTH-1] &&
                           ((smvlq_pkg::ACC_WIDTH+1)'(src_idx_ff) <
                            (smvlq_pkg::ACC_WIDTH+1)'(source_count_ff));
                  end
                  default: ;
               endcase
               if (field_ff < smvlq_pkg::FIELD_LIMIT) field_in = field_ff + 1'b1;
            end else if (dcount_inc >= smvlq_pkg::DC_WIDTH'(smvlq_pkg::MAX_VLQ_DIGITS)) begin
               partial_in = '0;
               dcount_in  = '0;
               skip_in    = 1'b1;
               err        = 1'b1;
            end else begin
               partial_in = shifted;
               dcount_in  = dcount_inc;
            end
         end

         // payload taken before the end-of-map clear
         eng.result.out_gen_line   = 32'(err_early ? gen_line_ff : gen_line_in);
         eng.result.out_gen_column = 32'(err_early ? gen_col_ff : gen_col_in);
         if (rec) begin
            eng.result.out_source_index  = src_idx_in[15:0];
            eng.result.out_source_line   = 32'(src_line_in);
            eng.result.out_source_column = 32'(src_col_in);
         end

         if (item.end_of_map) begin
            if (!(err_early || err || rec) && dcount_in != '0) err = 1'b1;
            gen_line_in = '0;
            gen_col_in  = '0;
            src_idx_in  = '0;
            src_line_in = '0;
            src_col_in  = '0;
            partial_in  = '0;
            dcount_in   = '0;
            field_in    = '0;
            skip_in     = 1'b0;
         end

         eng.has_result    = err_early || err || rec;
         eng.result.status = rec ? smvlq_pkg::STATUS_RECORD : smvlq_pkg::STATUS_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_count_ff <= '0;
         gen_line_ff     <= '0;
         gen_col_ff      <= '0;
         src_idx_ff      <= '0;
         src_line_ff     <= '0;
         src_col_ff      <= '0;
         partial_ff      <= '0;
         dcount_ff       <= '0;
         field_ff        <= '0;
         skip_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) source_count_ff <= csr_wr_data;
         gen_line_ff <= gen_line_in;
         gen_col_ff  <= gen_col_in;
         src_idx_ff  <= src_idx_in;
         src_line_ff <= src_line_in;
         src_col_ff  <= src_col_in;
         partial_ff  <= partial_in;
         dcount_ff   <= dcount_in;
         field_ff    <= field_in;
         skip_ff     <= skip_in;
      end
   end

   `SMVLQ_ASSERT_IMPL(a_dcount_bound, clock, reset, 1'b1, dcount_ff < smvlq_pkg::DC_WIDTH'(smvlq_pkg::MAX_VLQ_DIGITS))
   `SMVLQ_ASSERT_IMPL(a_record_on_fourth, clock, reset, eng.has_result && eng.result.status == smvlq_pkg::STATUS_RECORD, field_ff == smvlq_pkg::FIELD_SRC_COLUMN && !is_sep)
   `SMVLQ_ASSERT_IMPL(a_record_index_ok, clock, reset, eng.has_result && eng.result.status == smvlq_pkg::STATUS_RECORD, eng.result.out_source_index < source_count_ff)
   `SMVLQ_ASSERT_NEXT(a_clear_after_last, clock, reset, fire && item.end_of_map, gen_line_ff == '0 && field_ff == '0 && dcount_ff == '0 && !skip_ff)

endmodule

// ----- hw/rtl/smvlq_result_stage.sv -----
// Result register driving the output channel.
// Depends on smvlq_pkg and smvlq_rsp_if.
module smvlq_result_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  smvlq_pkg::smvlq_eng_out_type eng,
   input  logic                         fire,
   output logic                         can_load,
   smvlq_rsp_if.source                  rsp_ch
);

   logic                        valid_ff, valid_in;
   smvlq_pkg::smvlq_result_type data_ff;

   assign can_load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) valid_in = fire && eng.has_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && fire && eng.has_result) data_ff <= eng.result;
   end

   assign rsp_ch.valid             = valid_ff;
   assign rsp_ch.status            = data_ff.status;
   assign rsp_ch.out_gen_line      = data_ff.out_gen_line;
   assign rsp_ch.out_gen_column    = data_ff.out_gen_column;
   assign rsp_ch.out_source_index  = data_ff.out_source_index;
   assign rsp_ch.out_source_line   = data_ff.out_source_line;
   assign rsp_ch.out_source_column = data_ff.out_source_column;

endmodule

// ----- hw/rtl/source_map_vlq_mapping_decoder_core.sv -----
// Top level of the source map VLQ mappings decoder.
// Depends on smvlq_pkg, the channel interfaces and the three stage modules.
//
//   channel   dir  handshake             beat
//   req_ch    in   valid/ready           map_char, end_of_map
//   rsp_ch    out  valid/ready           status and five position fields
//   csr_*     in   csr_wr_en, no wait    source_count (16 bit)
//
// One character per cycle sustained while rsp_ch is not stalled; a taken beat is held
// in the input register, then decoded and added, and its outcome is loaded into the
// result register when decode fires on it, from which its result beat leaves.
// The accumulator feedback closes within the decode cycle, so back-to-back
// characters need no bubbles. A stalled result blocks decode, and the input
// register then fills and drops req ready. Synchronous reset clears all
// accumulators and source_count; no clearing pass.
module source_map_vlq_mapping_decoder_core (
   input  logic        clock,
   input  logic        reset,
   smvlq_req_if.sink   req_ch,
   smvlq_rsp_if.source rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   smvlq_pkg::smvlq_item_type    item;
   smvlq_pkg::smvlq_eng_out_type eng;
   logic                         can_load;
   logic                         fire;

   assign fire = item.valid && can_load;

   smvlq_input_stage u_input (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (can_load),
      .item   (item)
   );

   smvlq_decode_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .fire        (fire),
      .eng         (eng)
   );

   smvlq_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .eng      (eng),
      .fire     (fire),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule
